/* rtl/hkrb_pkg.sv */
`default_nettype none

package hkrb_pkg;

   // Default sizes
   localparam int KEY_SLOTS_DEF      = 6;
   localparam int LAYOUT_ENTRIES_DEF = 128;
   localparam int REPORT_SLOTS       = 6;

   // Configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_ALTGR_MASK = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SHIFT_MASK = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ISO_REPL   = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ISO_KEY    = 2'd3;

   localparam logic [7:0] ALTGR_MASK_RST = 8'd192;
   localparam logic [7:0] SHIFT_MASK_RST = 8'd128;

   // Key code ranges and modifier handling
   localparam logic [7:0] SPECIAL_BASE     = 8'd136;
   localparam logic [7:0] MOD_BASE         = 8'd128;
   localparam logic [7:0] ALTGR_MOD        = 8'h40;
   localparam logic [7:0] SHIFT_MOD        = 8'h02;
   localparam logic [7:0] ALTGR_USAGE_MASK = 8'h3F;
   localparam logic [7:0] SHIFT_USAGE_MASK = 8'h7F;

   typedef enum logic {
      OP_TABLE_WRITE = 1'b0,
      OP_ADD_KEY     = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [6:0]  table_index;
      logic [7:0]  table_value;
      logic [7:0]  key_code;
      logic        last_key;
   } req_type;

   typedef struct packed {
      logic [7:0]  modifier_bits;
      logic [7:0]  slot_zero;
      logic [7:0]  slot_one;
      logic [7:0]  slot_two;
      logic [7:0]  slot_three;
      logic [7:0]  slot_four;
      logic [7:0]  slot_five;
      logic        overflowed;
      logic        is_release;
      logic        run_end;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/hkrb_ram.sv */
`default_nettype none

// Simple dual-port RAM, one write and one registered read port
module hkrb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/hid_keyboard_report_builder.sv */
`default_nettype none

// Channel   Ports                          Direction  Item
// -------   -----------------------------  ---------  ---------------------------------
// request   req_valid, req_stall, req_data  in         table write or key add
// response  rsp_valid, rsp_stall, rsp_data  out        press report, then release report
// config    csr_we, csr_addr, csr_wdata     in         flag masks and ISO usage pair
//
// A table write completes at the edge it is accepted; a key add reads the layout RAM at
// that edge and updates the report at the next edge; adds follow every cycle unless stalled.
// A closing key sends a press report, then a release report, through one output register.
// Reset is synchronous and clears the report and flags; payload and layout RAM are not reset.
// A stall on the response side holds a closing key in the second stage and stalls requests.

module hid_keyboard_report_builder #(
   parameter int KEY_SLOTS      = hkrb_pkg::KEY_SLOTS_DEF,
   parameter int LAYOUT_ENTRIES = hkrb_pkg::LAYOUT_ENTRIES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire hkrb_pkg::req_type               req_data,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      hkrb_pkg::rsp_type               rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [hkrb_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [hkrb_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(LAYOUT_ENTRIES);

   logic req_acc;
   logic rsp_acc;

   // Configuration registers
   logic [7:0] altgr_mask_ff, altgr_mask_in;
   logic [7:0] shift_mask_ff, shift_mask_in;
   logic [7:0] iso_repl_ff,   iso_repl_in;
   logic [7:0] iso_key_ff,    iso_key_in;

   // Second stage
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_key_ff,   s1_key_in;
   logic       s1_last_ff,  s1_last_in;
   logic       s1_go;

   // Accumulated report
   logic [7:0] mods_ff,  mods_in;
   logic [7:0] slots_ff [KEY_SLOTS];
   logic [7:0] slots_in [KEY_SLOTS];
   logic       ovf_ff,   ovf_in;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   hkrb_pkg::rsp_type rsp_data_ff,  rsp_data_in;
   logic              rel_pend_ff,  rel_pend_in;
   logic              out_free;

   // Layout lookup and slot update
   logic [7:0] entry;
   logic [7:0] usage;
   logic [7:0] mod_set;
   logic [7:0] mods_next;
   logic [7:0] slots_next [KEY_SLOTS];
   logic       ovf_next;
   logic       present;
   logic       placed;
   logic [7:0] rep [hkrb_pkg::REPORT_SLOTS];
   hkrb_pkg::rsp_type press_rpt;
   hkrb_pkg::rsp_type release_rpt;

   assign req_acc = req_valid & ~req_stall;
   assign rsp_acc = rsp_valid_ff & ~rsp_stall;

   // Layout table
   hkrb_ram #(
      .WIDTH (8),
      .DEPTH (LAYOUT_ENTRIES)
   ) u_layout (
      .clock (clock),
      .we    (req_acc && req_data.opcode == hkrb_pkg::OP_TABLE_WRITE),
      .waddr (req_data.table_index[IDX_W-1:0]),
      .wdata (req_data.table_value),
      .re    (req_acc && req_data.opcode == hkrb_pkg::OP_ADD_KEY),
      .raddr (req_data.key_code[IDX_W-1:0]),
      .rdata (entry)
   );

   // Configuration writes
   always_comb begin
      altgr_mask_in = altgr_mask_ff;
      shift_mask_in = shift_mask_ff;
      iso_repl_in   = iso_repl_ff;
      iso_key_in    = iso_key_ff;
      if (csr_we) begin
         case (csr_addr)
            hkrb_pkg::CSR_ALTGR_MASK: altgr_mask_in = csr_wdata;
            hkrb_pkg::CSR_SHIFT_MASK: shift_mask_in = csr_wdata;
            hkrb_pkg::CSR_ISO_REPL:   iso_repl_in   = csr_wdata;
            hkrb_pkg::CSR_ISO_KEY:    iso_key_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // Output is free for a press report when empty or draining its last report
   assign out_free  = ~rsp_valid_ff | (rsp_acc & ~rel_pend_ff);
   assign s1_go     = s1_valid_ff & (~s1_last_ff | out_free);
   assign req_stall = s1_valid_ff & ~s1_go;

   // Second stage register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_key_in   = s1_key_ff;
      s1_last_in  = s1_last_ff;
      if (req_acc && req_data.opcode == hkrb_pkg::OP_ADD_KEY) begin
         s1_valid_in = 1'b1;
         s1_key_in   = req_data.key_code;
         s1_last_in  = req_data.last_key;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Key code to usage
   always_comb begin
      usage   = 8'd0;
      mod_set = 8'd0;
      if (s1_key_ff >= hkrb_pkg::SPECIAL_BASE) begin
         usage = s1_key_ff - hkrb_pkg::SPECIAL_BASE;
      end else if (s1_key_ff >= hkrb_pkg::MOD_BASE) begin
         mod_set = 8'd1 << s1_key_ff[2:0];
      end else begin
         if ((entry & altgr_mask_ff) == altgr_mask_ff) begin
            mod_set = hkrb_pkg::ALTGR_MOD;
            usage   = entry & hkrb_pkg::ALTGR_USAGE_MASK;
         end else if ((entry & shift_mask_ff) == shift_mask_ff) begin
            mod_set = hkrb_pkg::SHIFT_MOD;
            usage   = entry & hkrb_pkg::SHIFT_USAGE_MASK;
         end else begin
            usage = entry;
         end
         if (usage == iso_repl_ff) begin
            usage = iso_key_ff;
         end
      end
   end

   // Slot insert: skip if present (zero matches an empty slot), else first empty slot
   always_comb begin
      present = 1'b0;
      placed  = 1'b0;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         slots_next[i] = slots_ff[i];
         if (slots_ff[i] == usage) begin
            present = 1'b1;
         end
      end
      for (int i = 0; i < KEY_SLOTS; i++) begin
         if (!present && !placed && slots_ff[i] == 8'd0) begin
            slots_next[i] = usage;
            placed        = 1'b1;
         end
      end
      ovf_next  = ovf_ff | (~present & ~placed);
      mods_next = mods_ff | mod_set;
   end

   // Report state: update on each key, clear when a closing key loads the press report
   always_comb begin
      mods_in = mods_ff;
      ovf_in  = ovf_ff;
      for (int i = 0; i < KEY_SLOTS; i++) begin
         slots_in[i] = slots_ff[i];
      end
      if (s1_go) begin
         if (s1_last_ff) begin
            mods_in = 8'd0;
            ovf_in  = 1'b0;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               slots_in[i] = 8'd0;
            end
         end else begin
            mods_in = mods_next;
            ovf_in  = ovf_next;
            for (int i = 0; i < KEY_SLOTS; i++) begin
               slots_in[i] = slots_next[i];
            end
         end
      end
   end

   // Report images
   always_comb begin
      for (int j = 0; j < hkrb_pkg::REPORT_SLOTS; j++) begin
         rep[j] = 8'd0;
      end
      for (int j = 0; j < hkrb_pkg::REPORT_SLOTS && j < KEY_SLOTS; j++) begin
         rep[j] = slots_next[j];
      end
      press_rpt.modifier_bits = mods_next;
      press_rpt.slot_zero     = rep[0];
      press_rpt.slot_one      = rep[1];
      press_rpt.slot_two      = rep[2];
      press_rpt.slot_three    = rep[3];
      press_rpt.slot_four     = rep[4];
      press_rpt.slot_five     = rep[5];
      press_rpt.overflowed    = ovf_next;
      press_rpt.is_release    = 1'b0;
      press_rpt.run_end       = 1'b0;

      release_rpt            = '0;
      release_rpt.is_release = 1'b1;
      release_rpt.run_end    = 1'b1;
   end

   // Output register with a queued release report
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rel_pend_in  = rel_pend_ff;
      if (s1_go && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = press_rpt;
         rel_pend_in  = 1'b1;
      end else if (rsp_acc) begin
         if (rel_pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = release_rpt;
            rel_pend_in  = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   // Control and report registers
   always_ff @(posedge clock) begin
      if (reset) begin
         altgr_mask_ff <= hkrb_pkg::ALTGR_MASK_RST;
         shift_mask_ff <= hkrb_pkg::SHIFT_MASK_RST;
         iso_repl_ff   <= 8'd0;
         iso_key_ff    <= 8'd0;
         s1_valid_ff   <= 1'b0;
         mods_ff       <= 8'd0;
         ovf_ff        <= 1'b0;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= 8'd0;
         end
         rsp_valid_ff  <= 1'b0;
         rel_pend_ff   <= 1'b0;
      end else begin
         altgr_mask_ff <= altgr_mask_in;
         shift_mask_ff <= shift_mask_in;
         iso_repl_ff   <= iso_repl_in;
         iso_key_ff    <= iso_key_in;
         s1_valid_ff   <= s1_valid_in;
         mods_ff       <= mods_in;
         ovf_ff        <= ovf_in;
         for (int i = 0; i < KEY_SLOTS; i++) begin
            slots_ff[i] <= slots_in[i];
         end
         rsp_valid_ff  <= rsp_valid_in;
         rel_pend_ff   <= rel_pend_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_key_ff   <= s1_key_in;
      s1_last_ff  <= s1_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/hkrb_checker.sv */
`default_nettype none

module hkrb_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire hkrb_pkg::rsp_type rsp_data
);

   // A taken press report is followed at once by its release
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.is_release |=> rsp_valid && rsp_data.is_release)
      else $error("press report not followed by release");

   // Release report is all zero apart from its markers
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_release |->
         rsp_data.modifier_bits == 8'd0 && rsp_data.slot_zero == 8'd0 &&
         rsp_data.slot_one == 8'd0 && rsp_data.slot_two == 8'd0 &&
         rsp_data.slot_three == 8'd0 && rsp_data.slot_four == 8'd0 &&
         rsp_data.slot_five == 8'd0 && !rsp_data.overflowed && rsp_data.run_end)
      else $error("release report not clean");

   // Only the release ends a run
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_release |-> !rsp_data.run_end)
      else $error("press report marked as run end");

   // Stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
